[hw/rtl/assert_macros.svh]
// assertion macros used by xr_path_string_checker
// define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define XPSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// checked on every edge, reset included
`define XPSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`else

`define XPSC_ASSERT(lbl, clk, rst_n, prop)
`define XPSC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hw/rtl/xpsc_pkg.sv]
// ---------------------------------------------------------------------------
// xpsc_pkg
// Shared types and constants of the path string checker.
// ---------------------------------------------------------------------------
`default_nettype none

package xpsc_pkg;

  localparam int REASON_W = 4;
  localparam int LEN_W    = 9;

  // result reason codes
  localparam logic [REASON_W-1:0] R_OK      = 4'd0;
  localparam logic [REASON_W-1:0] R_LONG    = 4'd1;
  localparam logic [REASON_W-1:0] R_NOLEAD  = 4'd2;
  localparam logic [REASON_W-1:0] R_TRAIL   = 4'd3;
  localparam logic [REASON_W-1:0] R_DSLASH  = 4'd4;
  localparam logic [REASON_W-1:0] R_DOTCOMP = 4'd5;
  localparam logic [REASON_W-1:0] R_BADCH   = 4'd6;
  localparam logic [REASON_W-1:0] R_DOTEND  = 4'd7;
  localparam logic [REASON_W-1:0] R_EMPTY   = 4'd8;

  // character constants
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW    = $clog2(QDEPTH + 1);

  // classified character beat
  typedef struct packed {
    logic empty;
    logic slash;
    logic dot;
    logic legal;
    logic last;
  } xpsc_cls_t;

  typedef struct packed {
    logic           full;
    logic           empty;
    logic [QCW-1:0] count;
  } xpsc_q_status_t;

endpackage

`default_nettype wire

[hw/rtl/xpsc_front.sv]
// ---------------------------------------------------------------------------
// xpsc_front
// Classifies each incoming beat into empty, slash, dot, legal and last flags.
// ---------------------------------------------------------------------------
`default_nettype none

module xpsc_front (
  input  wire logic              in_kind,
  input  wire logic [7:0]        in_ch,
  input  wire logic              in_last,
  output xpsc_pkg::xpsc_cls_t    cls
);

  function automatic logic legal_char(input logic [7:0] c);
    logic ok;
    ok = ((c >= xpsc_pkg::CH_A) && (c <= xpsc_pkg::CH_Z)) ||
         ((c >= xpsc_pkg::CH_0) && (c <= xpsc_pkg::CH_9)) ||
         (c == xpsc_pkg::CH_DASH) || (c == xpsc_pkg::CH_UNDER) ||
         (c == xpsc_pkg::CH_DOT)  || (c == xpsc_pkg::CH_SLASH);
    return ok;
  endfunction

  always_comb begin
    cls.empty = in_kind;
    cls.slash = (in_ch == xpsc_pkg::CH_SLASH);
    cls.dot   = (in_ch == xpsc_pkg::CH_DOT);
    cls.legal = legal_char(in_ch);
    cls.last  = in_last;
  end

endmodule

`default_nettype wire

[hw/rtl/xpsc_queue.sv]
// ---------------------------------------------------------------------------
// xpsc_queue
// Short queue of classified beats between the front and the back.
// ---------------------------------------------------------------------------
`default_nettype none

module xpsc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire xpsc_pkg::xpsc_cls_t   push_data,
  input  wire logic                  pop,
  output xpsc_pkg::xpsc_cls_t        pop_data,
  output xpsc_pkg::xpsc_q_status_t   status
);

  localparam int D   = xpsc_pkg::QDEPTH;
  localparam int PW  = xpsc_pkg::QPW;
  localparam int CW  = xpsc_pkg::QCW;

  xpsc_pkg::xpsc_cls_t q_mem_r [D];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign status.full  = (count_r == CW'(D));
  assign status.empty = (count_r == '0);
  assign status.count = count_r;
  assign pop_data     = q_mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !status.full;
    do_pop     = pop && !status.empty;
    wr_ptr_nxt = (wr_ptr_r == PW'(D - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PW'(D - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop)  rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

[hw/rtl/xpsc_back.sv]
// ---------------------------------------------------------------------------
// xpsc_back
// Phase machine, length count and error latch; holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module xpsc_back #(
  parameter int MAX_PATH_LEN = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire xpsc_pkg::xpsc_cls_t           cls,
  input  wire logic                          q_empty,
  output logic                               take,
  output logic                               out_valid,
  input  wire logic                          out_pop,
  output logic                               out_path_ok,
  output logic [xpsc_pkg::REASON_W-1:0]      out_reason,
  output logic [xpsc_pkg::LEN_W-1:0]         out_path_length
);

  localparam int CW = $clog2(MAX_PATH_LEN + 1);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_SLASH = 2'd1,
    PH_DOTS  = 2'd2,
    PH_MID   = 2'd3
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic [xpsc_pkg::REASON_W-1:0]   err_r, err_nxt;
  logic                            out_valid_r;
  logic                            out_ok_r;
  logic [xpsc_pkg::REASON_W-1:0]   out_reason_r, reason_nxt;
  logic [xpsc_pkg::LEN_W-1:0]      out_len_r;
  logic [CW+xpsc_pkg::LEN_W-1:0]   cnt_ext;

  assign take            = !q_empty && (!out_valid_r || out_pop);
  assign out_valid       = out_valid_r;
  assign out_path_ok     = out_ok_r;
  assign out_reason      = out_reason_r;
  assign out_path_length = out_len_r;
  // length field keeps the low bits of the saturated count
  assign cnt_ext         = {{xpsc_pkg::LEN_W{1'b0}}, cnt_nxt};

  always_comb begin
    cnt_nxt   = (cnt_r < CW'(MAX_PATH_LEN)) ? cnt_r + 1'b1 : cnt_r;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    unique case (phase_r)
      PH_START: begin
        if (!cls.slash && err_r == xpsc_pkg::R_OK) err_nxt = xpsc_pkg::R_NOLEAD;
        phase_nxt = PH_SLASH;
      end
      PH_SLASH: begin
        if (cls.dot) begin
          phase_nxt = PH_DOTS;
        end else if (cls.slash) begin
          if (err_r == xpsc_pkg::R_OK) err_nxt = xpsc_pkg::R_DSLASH;
        end else begin
          if (!cls.legal && err_r == xpsc_pkg::R_OK) err_nxt = xpsc_pkg::R_BADCH;
          phase_nxt = PH_MID;
        end
      end
      PH_DOTS: begin
        if (cls.slash) begin
          if (err_r == xpsc_pkg::R_OK) err_nxt = xpsc_pkg::R_DOTCOMP;
          phase_nxt = PH_SLASH;
        end else if (!cls.dot) begin
          if (!cls.legal && err_r == xpsc_pkg::R_OK) err_nxt = xpsc_pkg::R_BADCH;
          phase_nxt = PH_MID;
        end
      end
      PH_MID: begin
        if (cls.slash) begin
          phase_nxt = PH_SLASH;
        end else if (!cls.legal && err_r == xpsc_pkg::R_OK) begin
          err_nxt = xpsc_pkg::R_BADCH;
        end
      end
      default: phase_nxt = PH_START;
    endcase

    priority if (cnt_nxt == CW'(MAX_PATH_LEN)) begin
      reason_nxt = xpsc_pkg::R_LONG;
    end else if (err_nxt == xpsc_pkg::R_NOLEAD) begin
      reason_nxt = xpsc_pkg::R_NOLEAD;
    end else if (cls.slash) begin
      reason_nxt = xpsc_pkg::R_TRAIL;
    end else if (err_nxt != xpsc_pkg::R_OK) begin
      reason_nxt = err_nxt;
    end else if (phase_nxt == PH_DOTS) begin
      reason_nxt = xpsc_pkg::R_DOTEND;
    end else begin
      reason_nxt = xpsc_pkg::R_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      cnt_r       <= '0;
      err_r       <= xpsc_pkg::R_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (take && (cls.empty || cls.last)) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (cls.empty) begin
          // empty beat drops any pending path
          phase_r      <= PH_START;
          cnt_r        <= '0;
          err_r        <= xpsc_pkg::R_OK;
          out_ok_r     <= 1'b0;
          out_reason_r <= xpsc_pkg::R_EMPTY;
          out_len_r    <= '0;
        end else if (cls.last) begin
          phase_r      <= PH_START;
          cnt_r        <= '0;
          err_r        <= xpsc_pkg::R_OK;
          out_ok_r     <= (reason_nxt == xpsc_pkg::R_OK);
          out_reason_r <= reason_nxt;
          out_len_r    <= cnt_ext[xpsc_pkg::LEN_W-1:0];
        end else begin
          phase_r <= phase_nxt;
          cnt_r   <= cnt_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/xr_path_string_checker.sv]
// ---------------------------------------------------------------------------
// xr_path_string_checker
// Streaming path string validator, one character beat per cycle when not stalled.
// ---------------------------------------------------------------------------
// Characters arrive one per beat with in_last on the final one; an empty path
// is a single beat with in_kind set. Each path gives one result beat with an
// ok bit, a reason code and the saturated length. The back end takes one beat
// per cycle while the queue holds one and the result register is free or being
// popped; a beat ending its path passes through the queue, then the result
// register, before it shows on the output ports, and a two-entry queue lets
// input and output stall independently.
`default_nettype none

`include "assert_macros.svh"

module xr_path_string_checker #(
  parameter int MAX_PATH_LEN = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_kind,
  input  wire logic [7:0]                    in_ch,
  input  wire logic                          in_last,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic                               out_path_ok,
  output logic [xpsc_pkg::REASON_W-1:0]      out_reason,
  output logic [xpsc_pkg::LEN_W-1:0]         out_path_length
);

  xpsc_pkg::xpsc_cls_t      front_cls;
  xpsc_pkg::xpsc_cls_t      back_cls;
  xpsc_pkg::xpsc_q_status_t q_status;
  logic                     back_take;
  logic                     out_valid;

  xpsc_front u_front (
    .in_kind (in_kind),
    .in_ch   (in_ch),
    .in_last (in_last),
    .cls     (front_cls)
  );

  xpsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_cls),
    .pop       (back_take),
    .pop_data  (back_cls),
    .status    (q_status)
  );

  xpsc_back #(
    .MAX_PATH_LEN (MAX_PATH_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cls             (back_cls),
    .q_empty         (q_status.empty),
    .take            (back_take),
    .out_valid       (out_valid),
    .out_pop         (out_pop),
    .out_path_ok     (out_path_ok),
    .out_reason      (out_reason),
    .out_path_length (out_path_length)
  );

  assign in_full   = q_status.full;
  assign out_empty = !out_valid;

  // queue occupancy never passes its depth
  `XPSC_ASSERT(a_q_bound, clk, rst_n, q_status.count <= xpsc_pkg::QCW'(xpsc_pkg::QDEPTH))
  // nothing to pop right after a reset edge
  `XPSC_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> out_empty)
  // an empty path always reports zero length and not ok
  `XPSC_ASSERT(a_empty_len, clk, rst_n, (!out_empty && out_reason == xpsc_pkg::R_EMPTY) |-> (out_path_length == '0 && !out_path_ok))
  // ok flag tracks the reason code
  `XPSC_ASSERT(a_ok_reason, clk, rst_n, !out_empty |-> (out_path_ok == (out_reason == xpsc_pkg::R_OK)))

endmodule

`default_nettype wire

[tb/sv/xpsc_result_checker.sv]
// ---------------------------------------------------------------------------
// xpsc_result_checker
// Beat monitor and scoreboard for the path string checker.
// ---------------------------------------------------------------------------
// Watches every accepted input beat, runs its own copy of the phase machine to
// work out the verdict of each finished path, and compares every popped result
// beat against the oldest outstanding verdict. Mismatches are counted and
// handed to the top; pending tells how many verdicts are still outstanding.
module xpsc_result_checker
  import xpsc_pkg::*;
#(
  parameter int MAX_LEN = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  logic                in_kind,
  input  logic [7:0]          in_ch,
  input  logic                in_last,
  input  logic                out_empty,
  input  logic                out_pop,
  input  logic                out_path_ok,
  input  logic [REASON_W-1:0] out_reason,
  input  logic [LEN_W-1:0]    out_path_length,
  output int                  fail_count,
  output int                  pending,
  output int                  results_seen,
  output logic [8:0]          reasons_seen
);

  typedef enum logic [1:0] {
    PH_START,
    PH_SLASH,
    PH_DOTS,
    PH_MID
  } scan_phase_e;

  typedef struct packed {
    logic                ok;
    logic [REASON_W-1:0] reason;
    logic [LEN_W-1:0]    len;
  } path_verdict_t;

  scan_phase_e         phase;
  int                  char_cnt;
  logic [REASON_W-1:0] first_err;
  path_verdict_t       expected_verdicts[$];
  int                  mismatches = 0;
  int                  checked = 0;
  logic [8:0]          reason_hits = '0;

  assign fail_count   = mismatches;
  assign results_seen = checked;
  assign reasons_seen = reason_hits;

  function automatic logic is_legal(logic [7:0] c);
    return (c >= CH_A && c <= CH_Z) || (c >= CH_0 && c <= CH_9) ||
           c == CH_DASH || c == CH_UNDER || c == CH_DOT || c == CH_SLASH;
  endfunction

  // only the first error of a path sticks
  function automatic logic [REASON_W-1:0] keep_first(logic [REASON_W-1:0] cur,
                                                     logic [REASON_W-1:0] code);
    return (cur == R_OK) ? code : cur;
  endfunction

  always @(posedge clk) begin
    path_verdict_t       want;
    path_verdict_t       got;
    logic [REASON_W-1:0] why;
    if (!rst_n) begin
      phase     = PH_START;
      char_cnt  = 0;
      first_err = R_OK;
      expected_verdicts.delete();
      pending <= 0;
    end else begin
      if (in_push && !in_full) begin
        if (in_kind) begin
          // an empty beat drops whatever path was in flight
          expected_verdicts.push_back({1'b0, R_EMPTY, {LEN_W{1'b0}}});
          phase     = PH_START;
          char_cnt  = 0;
          first_err = R_OK;
        end else begin
          if (char_cnt < MAX_LEN) char_cnt++;
          case (phase)
            PH_START: begin
              if (in_ch != CH_SLASH) first_err = keep_first(first_err, R_NOLEAD);
              phase = PH_SLASH;
            end
            PH_SLASH: begin
              if (in_ch == CH_DOT) begin
                phase = PH_DOTS;
              end else if (in_ch == CH_SLASH) begin
                first_err = keep_first(first_err, R_DSLASH);
              end else begin
                if (!is_legal(in_ch)) first_err = keep_first(first_err, R_BADCH);
                phase = PH_MID;
              end
            end
            PH_DOTS: begin
              if (in_ch == CH_SLASH) begin
                first_err = keep_first(first_err, R_DOTCOMP);
                phase     = PH_SLASH;
              end else if (in_ch != CH_DOT) begin
                if (!is_legal(in_ch)) first_err = keep_first(first_err, R_BADCH);
                phase = PH_MID;
              end
            end
            default: begin
              if (in_ch == CH_SLASH) begin
                phase = PH_SLASH;
              end else if (!is_legal(in_ch)) begin
                first_err = keep_first(first_err, R_BADCH);
              end
            end
          endcase
          if (in_last) begin
            if (char_cnt >= MAX_LEN) why = R_LONG;
            else if (first_err == R_NOLEAD) why = R_NOLEAD;
            else if (in_ch == CH_SLASH) why = R_TRAIL;
            else if (first_err != R_OK) why = first_err;
            else if (phase == PH_DOTS) why = R_DOTEND;
            else why = R_OK;
            expected_verdicts.push_back({why == R_OK, why, char_cnt[LEN_W-1:0]});
            phase     = PH_START;
            char_cnt  = 0;
            first_err = R_OK;
          end
        end
      end

      if (!out_empty && out_pop) begin
        got = {out_path_ok, out_reason, out_path_length};
        checked++;
        if (expected_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: ok=%0d reason=%0d len=%0d",
                     out_path_ok, out_reason, out_path_length);
        end else begin
          want = expected_verdicts.pop_front();
          reason_hits[want.reason] = 1'b1;
          if (got.ok !== want.ok || got.reason !== want.reason || got.len !== want.len) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected ok=%0d reason=%0d len=%0d, got ok=%0d reason=%0d len=%0d",
                       checked, want.ok, want.reason, want.len,
                       got.ok, got.reason, got.len);
          end
        end
      end

      pending <= expected_verdicts.size();
    end
  end

endmodule

[tb/sv/tb_xr_path_string_checker.sv]
// ---------------------------------------------------------------------------
// tb_xr_path_string_checker
// Stimulus and verdict for the path string checker.
// ---------------------------------------------------------------------------
// Sends a short directed set of paths covering each reason code but R_LONG and the
// empty-beat abort, then random paths: mostly well-formed with random content,
// some broken on purpose, a few at the length limit. Both the push and pop
// sides stall at random; the scoreboard module does all the checking.
module tb_xr_path_string_checker;
  import xpsc_pkg::*;

  localparam int MAX_LEN    = 256;
  localparam int ITEM_GOAL  = 1200;
  localparam int CYCLE_CAP  = 800000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_push = 1'b0;
  logic                in_kind = 1'b0;
  logic [7:0]          in_ch = '0;
  logic                in_last = 1'b0;
  logic                out_pop = 1'b0;
  logic                in_full;
  logic                out_empty;
  logic                out_path_ok;
  logic [REASON_W-1:0] out_reason;
  logic [LEN_W-1:0]    out_path_length;

  int                  fail_count;
  int                  pending;
  int                  results_seen;
  logic [8:0]          reasons_seen;

  int                  cycle_cnt = 0;
  int                  beats_sent = 0;
  int                  paths_sent = 0;
  bit                  quiet_push = 1'b0;
  bit                  quiet_pop = 1'b0;
  logic [7:0]          path_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  xr_path_string_checker #(
    .MAX_PATH_LEN(MAX_LEN)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_path_ok    (out_path_ok),
    .out_reason     (out_reason),
    .out_path_length(out_path_length)
  );

  xpsc_result_checker #(
    .MAX_LEN(MAX_LEN)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_kind        (in_kind),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_path_ok    (out_path_ok),
    .out_reason     (out_reason),
    .out_path_length(out_path_length),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .reasons_seen   (reasons_seen)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
      $display("xr_path_string_checker: mismatch");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] legal_pick();
    int r;
    r = $urandom_range(0, 38);
    if (r < 26) return CH_A + 8'(r);
    if (r < 36) return CH_0 + 8'(r - 26);
    if (r == 36) return CH_DASH;
    if (r == 37) return CH_UNDER;
    return CH_DOT;
  endfunction

  // receiver: pops with random stalls
  initial begin
    int stall;
    stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        stall = pick_gap(quiet_pop);
        if ($urandom_range(0, 49) == 0) quiet_pop = !quiet_pop;
      end
      @(posedge clk);
    end
  end

  task automatic send_beat(logic kind, logic [7:0] ch, logic last);
    int gap;
    gap = pick_gap(quiet_push);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_kind <= kind;
    in_ch   <= ch;
    in_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_text(string s, bit ends);
    for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i], ends && i == s.len() - 1);
    if (ends) paths_sent++;
  endtask

  task automatic send_empty();
    send_beat(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    paths_sent++;
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // fills path_q with one path: mostly well formed, some broken on purpose
  task automatic build_path(int target);
    int ncomp;
    int kind_sel;
    int idx;
    path_q.delete();
    path_q.push_back(CH_SLASH);
    if (target > 0) begin
      // long path of plain letters and slashes, cut to the exact length
      while (path_q.size() < target) begin
        if (path_q[$] != CH_SLASH && $urandom_range(0, 7) == 0) path_q.push_back(CH_SLASH);
        else path_q.push_back(CH_A + 8'($urandom_range(0, 25)));
      end
      if (path_q[$] == CH_SLASH) path_q[$] = CH_Z;
      return;
    end
    ncomp = $urandom_range(1, 4);
    for (int c = 0; c < ncomp; c++) begin
      if (c > 0) path_q.push_back(CH_SLASH);
      kind_sel = $urandom_range(0, 9);
      if (kind_sel == 0) begin
        repeat ($urandom_range(1, 3)) path_q.push_back(CH_DOT);
      end else begin
        repeat ($urandom_range(1, 6)) path_q.push_back(legal_pick());
      end
    end
    if ($urandom_range(0, 99) < 35) begin
      idx = $urandom_range(0, path_q.size() - 1);
      case ($urandom_range(0, 5))
        0: path_q[0] = ($urandom_range(0, 1) != 0) ? legal_pick() : 8'($urandom_range(0, 255));
        1: path_q.push_back(CH_SLASH);
        2: begin
          path_q.insert(idx + 1, CH_SLASH);
          path_q.insert(idx + 1, CH_SLASH);
        end
        3: path_q[idx] = 8'($urandom_range(0, 255));
        4: begin
          path_q.push_back(CH_SLASH);
          repeat ($urandom_range(1, 2)) path_q.push_back(CH_DOT);
        end
        default: path_q[idx] = 8'($urandom_range(8'h41, 8'h5a));
      endcase
    end
  endtask

  initial begin
    int sel;
    int long_cnt;
    long_cnt = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: one of each verdict but R_LONG, then an aborted path
    send_text("/a", 1'b1);
    send_empty();
    send_text("/", 1'b1);
    send_text("x", 1'b1);
    send_text("/z-_9", 1'b1);
    send_text("//a", 1'b1);
    send_text("/./a", 1'b1);
    send_beat(1'b0, CH_SLASH, 1'b0);
    send_beat(1'b0, 8'hff, 1'b1);
    paths_sent++;
    send_text("/..", 1'b1);
    send_text("/a", 1'b0);
    send_empty();
    wait_drained();

    while (beats_sent < ITEM_GOAL) begin
      sel = $urandom_range(0, 99);
      if (paths_sent % 25 == 10 && long_cnt < 3) begin
        // around the length limit: just under, at, and just over
        build_path(MAX_LEN - 1 + long_cnt + (long_cnt == 2 ? $urandom_range(0, 6) : 0));
        long_cnt++;
      end else if (sel < 5) begin
        send_empty();
        continue;
      end else begin
        build_path(0);
      end
      if (sel >= 5 && sel < 9) begin
        // drop the path partway through with an empty beat
        sel = $urandom_range(0, path_q.size() - 1);
        for (int i = 0; i <= sel; i++) send_beat(1'b0, path_q[i], 1'b0);
        send_empty();
      end else begin
        for (int i = 0; i < path_q.size(); i++)
          send_beat(1'b0, path_q[i], i == path_q.size() - 1);
        paths_sent++;
      end
      if ($urandom_range(0, 19) == 0) quiet_push = !quiet_push;
      // let everything drain once in a while before going on
      if (paths_sent % 50 == 25) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("sent %0d input beats in %0d paths, checked %0d result beats",
             beats_sent, paths_sent, results_seen);
    $display("reason codes seen (bit per code, 8 down to 0): %b", reasons_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("xr_path_string_checker: match");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("xr_path_string_checker: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/xpsc_pkg.sv
hw/rtl/xpsc_front.sv
hw/rtl/xpsc_queue.sv
hw/rtl/xpsc_back.sv
hw/rtl/xr_path_string_checker.sv
tb/sv/xpsc_result_checker.sv
tb/sv/tb_xr_path_string_checker.sv
